@@ rtl/tli_pkg.sv @@
// tli_pkg: shared types, constants and helper functions of the table linear interpolator
// no dependencies; imported by every module of the block except tli_ram
package tli_pkg;

   localparam int DATA_W      = 48;
   localparam int TABLE_DEPTH = 1024;
   localparam int NUM_COLUMNS = 9;
   localparam int FRAC_BITS   = 28;

   localparam int CMD_W    = 2;
   localparam int ROW_W    = 10;
   localparam int COL_W    = 4;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 11;

   localparam int XA_W      = $clog2(TABLE_DEPTH);
   localparam int ORD_DEPTH = NUM_COLUMNS * TABLE_DEPTH;
   localparam int YA_W      = $clog2(ORD_DEPTH);
   localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
   // wide enough for the full product of a slope magnitude and the fraction
   localparam int ALU_W     = DATA_W + 1 + FRAC_BITS;
   localparam int LAM_W     = FRAC_BITS + 1;
   localparam int IT_W      = $clog2(FRAC_BITS + 1);

   localparam logic [CMD_W-1:0] CMD_WRITE_ABSCISSA = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_ORDINATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVALUATE       = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_INTERIOR = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FIRST    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LAST     = 2'd2;

   localparam logic [CFG_W-1:0] VALID_ENTRIES_RESET = 11'd2;

   localparam logic [LAM_W-1:0]        LAM_FULL   = LAM_W'(1) << FRAC_BITS;
   localparam logic signed [ALU_W-1:0] ROUND_HALF = ALU_W'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [ROW_W-1:0]         row_index;
      logic [COL_W-1:0]         column_select;
      logic signed [DATA_W-1:0] write_value;
      logic signed [DATA_W-1:0] query_point;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] interpolated_value;
      logic [STATUS_W-1:0]      clamp_status;
   } rsp_type;

   typedef struct packed {
      logic              x_en;
      logic [XA_W-1:0]   x_addr;
      logic              y_en;
      logic [YA_W-1:0]   y_addr;
   } mem_rd_type;

   typedef struct packed {
      logic                    subtract;
      logic signed [ALU_W-1:0] a;
      logic signed [ALU_W-1:0] b;
   } alu_ctrl_type;

   typedef struct packed {
      logic signed [ALU_W-1:0] sum;
      logic                    negative;
      logic                    zero;
   } alu_res_type;

   function automatic logic [CNT_W-1:0] rows_in_use(input logic [CFG_W-1:0] ve);
      logic [31:0] v;
      v = 32'(ve);
      if (v < 32'd2) begin
         v = 32'd2;
      end else if (v > 32'(TABLE_DEPTH)) begin
         v = 32'(TABLE_DEPTH);
      end
      return CNT_W'(v);
   endfunction

   function automatic logic row_in_range(input logic [ROW_W-1:0] row);
      return 32'(row) < 32'(TABLE_DEPTH);
   endfunction

   function automatic logic col_in_range(input logic [COL_W-1:0] col);
      return 32'(col) < 32'(NUM_COLUMNS);
   endfunction

   // columns are stacked one after another in the ordinate memory
   function automatic logic [YA_W-1:0] ord_addr(input logic [COL_W-1:0] col,
                                                 input logic [XA_W-1:0] row);
      return YA_W'(32'(col) * 32'(TABLE_DEPTH) + 32'(row));
   endfunction

   function automatic logic signed [ALU_W-1:0] widen(input logic signed [DATA_W-1:0] v);
      return ALU_W'(v);
   endfunction

endpackage

@@ rtl/table_linear_interpolator.sv @@
// Write items: one per cycle while idle, no result. Evaluate: ready drops for the
// whole item. Interior point: the shared adder runs the search probes, up to FRAC_BITS
// division steps and FRAC_BITS+1 shift-add steps. Reset clears control and sets
// valid_entries to 2; the tables are not cleared. Depends on tli_pkg, tli_ram, tli_alu,
// tli_seq.
module table_linear_interpolator
   import tli_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   logic [CFG_W-1:0] valid_entries_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic                     req_accept;
   logic                     x_wr_en;
   logic                     y_wr_en;
   mem_rd_type               mem_rd;
   logic signed [DATA_W-1:0] x_rd_data;
   logic signed [DATA_W-1:0] y_rd_data;
   alu_ctrl_type             alu_ctrl;
   alu_res_type              alu_res;
   logic                     emit_valid;
   logic                     emit_ready;
   rsp_type                  emit_data;

   assign req_accept = req_valid && req_ready;
   assign x_wr_en    = req_accept && (req_data.command == CMD_WRITE_ABSCISSA)
                       && row_in_range(req_data.row_index);
   assign y_wr_en    = req_accept && (req_data.command == CMD_WRITE_ORDINATE)
                       && row_in_range(req_data.row_index)
                       && col_in_range(req_data.column_select);

   tli_ram #(
      .DEPTH  (TABLE_DEPTH),
      .WIDTH  (DATA_W),
      .ADDR_W (XA_W)
   ) u_abscissa_ram (
      .clock   (clock),
      .wr_en   (x_wr_en),
      .wr_addr (XA_W'(req_data.row_index)),
      .wr_data (req_data.write_value),
      .rd_en   (mem_rd.x_en),
      .rd_addr (mem_rd.x_addr),
      .rd_data (x_rd_data)
   );

   tli_ram #(
      .DEPTH  (ORD_DEPTH),
      .WIDTH  (DATA_W),
      .ADDR_W (YA_W)
   ) u_ordinate_ram (
      .clock   (clock),
      .wr_en   (y_wr_en),
      .wr_addr (ord_addr(req_data.column_select, XA_W'(req_data.row_index))),
      .wr_data (req_data.write_value),
      .rd_en   (mem_rd.y_en),
      .rd_addr (mem_rd.y_addr),
      .rd_data (y_rd_data)
   );

   tli_alu u_alu (
      .ctrl (alu_ctrl),
      .res  (alu_res)
   );

   tli_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .valid_entries (valid_entries_ff),
      .mem_rd        (mem_rd),
      .x_rd_data     (x_rd_data),
      .y_rd_data     (y_rd_data),
      .alu_ctrl      (alu_ctrl),
      .alu_res       (alu_res),
      .emit_valid    (emit_valid),
      .emit_ready    (emit_ready),
      .emit_data     (emit_data)
   );

   // output register frees the sequencer while the item waits downstream
   assign emit_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_entries_ff <= VALID_ENTRIES_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            valid_entries_ff <= csr_wr_data;
         end
         if (emit_valid && emit_ready) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= emit_data;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/tli_ram.sv @@
// tli_ram: generic single-port-write, single-port-read memory with registered read data
// standalone, no package needed
module tli_ram #(
   parameter int DEPTH  = 2,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tli_alu.sv @@
// tli_alu: the one shared adder/subtractor used for every compare, division and
// shift-add step of an evaluation; depends on tli_pkg
module tli_alu
   import tli_pkg::*;
(
   input  alu_ctrl_type ctrl,
   output alu_res_type  res
);

   logic signed [ALU_W-1:0] b_eff;
   logic signed [ALU_W-1:0] sum;

   always_comb begin
      b_eff = ctrl.subtract ? ~ctrl.b : ctrl.b;
      sum   = ctrl.a + b_eff + ALU_W'(ctrl.subtract);
   end

   assign res.sum      = sum;
   assign res.negative = sum[ALU_W-1];
   assign res.zero     = (sum == '0);

endmodule

@@ rtl/tli_seq.sv @@
// tli_seq: evaluation sequencer: clamp checks, binary search, restoring division,
// shift-add blend, all driving the shared adder; depends on tli_pkg
module tli_seq
   import tli_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   input  logic [CFG_W-1:0]         valid_entries,
   output mem_rd_type               mem_rd,
   input  logic signed [DATA_W-1:0] x_rd_data,
   input  logic signed [DATA_W-1:0] y_rd_data,
   output alu_ctrl_type             alu_ctrl,
   input  alu_res_type              alu_res,
   output logic                     emit_valid,
   input  logic                     emit_ready,
   output rsp_type                  emit_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_CHK_LO, S_CHK_HI, S_SRCH_ADDR, S_SRCH_CMP, S_LD_X0, S_LD_X1,
      S_CALC_NUM, S_CMP_ND, S_DIV, S_DIFF, S_NEG, S_MUL, S_RND, S_FIN,
      S_LD_CLAMP, S_EMIT
   } state_type;

   state_type                state_ff;
   logic [COL_W-1:0]         col_ff;
   logic signed [DATA_W-1:0] query_ff;
   logic [CNT_W-1:0]         n_ff;
   logic [CNT_W-1:0]         lo_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [XA_W-1:0]          off_ff;
   logic signed [DATA_W-1:0] x0_ff;
   logic signed [DATA_W-1:0] y0_ff;
   logic signed [DATA_W-1:0] y1_ff;
   logic signed [ALU_W-1:0]  den_ff;
   logic signed [ALU_W-1:0]  rem_ff;
   logic signed [ALU_W-1:0]  diff_ff;
   logic signed [ALU_W-1:0]  acc_ff;
   logic                     den_le0_ff;
   logic                     neg_ff;
   logic [LAM_W-1:0]         lam_ff;
   logic [IT_W-1:0]          it_ff;
   logic signed [DATA_W-1:0] res_ff;
   logic [STATUS_W-1:0]      status_ff;

   logic [CNT_W-1:0] step;
   logic [CNT_W-1:0] probe;
   logic [CNT_W-1:0] lo_m1;
   logic [CNT_W-1:0] n_m1;
   logic [CNT_W-1:0] n_m2;
   logic [CNT_W-1:0] off_calc;
   logic             col_ok;

   always_comb begin
      step     = cnt_ff >> 1;
      probe    = lo_ff + step;
      lo_m1    = (lo_ff == '0) ? '0 : lo_ff - 1'b1;
      n_m1     = n_ff - 1'b1;
      n_m2     = n_ff - CNT_W'(2);
      // interval index kept inside the table even for a non-ascending one
      off_calc = (lo_m1 > n_m2) ? n_m2 : lo_m1;
      col_ok   = col_in_range(col_ff);
   end

   always_comb begin
      mem_rd            = '0;
      alu_ctrl.subtract = 1'b0;
      alu_ctrl.a        = '0;
      alu_ctrl.b        = '0;
      unique case (state_ff)
         S_IDLE: begin
            mem_rd.x_en   = req_valid && (req_data.command == CMD_EVALUATE);
            mem_rd.x_addr = '0;
         end
         S_CHK_LO: begin
            alu_ctrl.subtract = 1'b1;
            alu_ctrl.a        = widen(x_rd_data);
            alu_ctrl.b        = widen(query_ff);
            if (!alu_res.negative) begin
               mem_rd.y_en   = col_ok;
               mem_rd.y_addr = ord_addr(col_ff, '0);
            end else begin
               mem_rd.x_en   = 1'b1;
               mem_rd.x_addr = XA_W'(n_m1);
            end
         end
         S_CHK_HI: begin
            alu_ctrl.subtract = 1'b1;
            alu_ctrl.a        = widen(query_ff);
            alu_ctrl.b        = widen(x_rd_data);
            if (!alu_res.negative) begin
               mem_rd.y_en   = col_ok;
               mem_rd.y_addr = ord_addr(col_ff, XA_W'(n_m1));
            end
         end
         S_SRCH_ADDR: begin
            mem_rd.x_en   = 1'b1;
            mem_rd.x_addr = (cnt_ff == '0) ? XA_W'(off_calc) : XA_W'(probe);
         end
         S_SRCH_CMP: begin
            alu_ctrl.subtract = 1'b1;
            alu_ctrl.a        = widen(x_rd_data);
            alu_ctrl.b        = widen(query_ff);
         end
         S_LD_X0: begin
            mem_rd.x_en   = 1'b1;
            mem_rd.x_addr = XA_W'(off_ff + 1'b1);
            mem_rd.y_en   = col_ok;
            mem_rd.y_addr = ord_addr(col_ff, off_ff);
         end
         S_LD_X1: begin
            alu_ctrl.subtract = 1'b1;
            alu_ctrl.a        = widen(x_rd_data);
            alu_ctrl.b        = widen(x0_ff);
            mem_rd.y_en       = col_ok;
            mem_rd.y_addr     = ord_addr(col_ff, XA_W'(off_ff + 1'b1));
         end
         S_CALC_NUM: begin
            alu_ctrl.subtract = 1'b1;
            alu_ctrl.a        = widen(query_ff);
            alu_ctrl.b        = widen(x0_ff);
         end
         S_CMP_ND: begin
            alu_ctrl.subtract = 1'b1;
            alu_ctrl.a        = rem_ff;
            alu_ctrl.b        = den_ff;
         end
         S_DIV: begin
            alu_ctrl.subtract = 1'b1;
            alu_ctrl.a        = rem_ff <<< 1;
            alu_ctrl.b        = den_ff;
         end
         S_DIFF: begin
            alu_ctrl.subtract = 1'b1;
            alu_ctrl.a        = widen(y1_ff);
            alu_ctrl.b        = widen(y0_ff);
         end
         S_NEG: begin
            alu_ctrl.subtract = 1'b1;
            alu_ctrl.a        = '0;
            alu_ctrl.b        = diff_ff;
         end
         S_MUL: begin
            // fraction bits taken msb first
            alu_ctrl.a = acc_ff <<< 1;
            alu_ctrl.b = lam_ff[LAM_W-1] ? diff_ff : '0;
         end
         S_RND: begin
            alu_ctrl.a = acc_ff;
            alu_ctrl.b = ROUND_HALF;
         end
         S_FIN: begin
            alu_ctrl.subtract = neg_ff;
            alu_ctrl.a        = widen(y0_ff);
            alu_ctrl.b        = acc_ff >>> FRAC_BITS;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && (req_data.command == CMD_EVALUATE)) begin
                  col_ff   <= req_data.column_select;
                  query_ff <= req_data.query_point;
                  n_ff     <= rows_in_use(valid_entries);
                  state_ff <= S_CHK_LO;
               end
            end
            S_CHK_LO: begin
               if (!alu_res.negative) begin
                  status_ff <= STATUS_FIRST;
                  state_ff  <= S_LD_CLAMP;
               end else begin
                  state_ff <= S_CHK_HI;
               end
            end
            S_CHK_HI: begin
               if (!alu_res.negative) begin
                  status_ff <= STATUS_LAST;
                  state_ff  <= S_LD_CLAMP;
               end else begin
                  status_ff <= STATUS_INTERIOR;
                  lo_ff     <= '0;
                  cnt_ff    <= n_ff;
                  state_ff  <= S_SRCH_ADDR;
               end
            end
            S_SRCH_ADDR: begin
               if (cnt_ff == '0) begin
                  off_ff   <= XA_W'(off_calc);
                  state_ff <= S_LD_X0;
               end else begin
                  state_ff <= S_SRCH_CMP;
               end
            end
            S_SRCH_CMP: begin
               // lower-bound step: probe below the query moves the window up
               if (alu_res.negative) begin
                  lo_ff  <= probe + 1'b1;
                  cnt_ff <= cnt_ff - step - 1'b1;
               end else begin
                  cnt_ff <= step;
               end
               state_ff <= S_SRCH_ADDR;
            end
            S_LD_X0: begin
               x0_ff    <= x_rd_data;
               state_ff <= S_LD_X1;
            end
            S_LD_X1: begin
               den_ff     <= alu_res.sum;
               den_le0_ff <= alu_res.negative || alu_res.zero;
               y0_ff      <= y_rd_data;
               state_ff   <= S_CALC_NUM;
            end
            S_CALC_NUM: begin
               rem_ff <= alu_res.sum;
               y1_ff  <= y_rd_data;
               lam_ff <= '0;
               if (den_le0_ff || alu_res.negative || alu_res.zero) begin
                  state_ff <= S_DIFF;
               end else begin
                  state_ff <= S_CMP_ND;
               end
            end
            S_CMP_ND: begin
               if (!alu_res.negative) begin
                  lam_ff   <= LAM_FULL;
                  state_ff <= S_DIFF;
               end else begin
                  it_ff    <= IT_W'(FRAC_BITS - 1);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (!alu_res.negative) begin
                  rem_ff <= alu_res.sum;
               end else begin
                  rem_ff <= rem_ff <<< 1;
               end
               lam_ff <= {lam_ff[LAM_W-2:0], !alu_res.negative};
               it_ff  <= it_ff - 1'b1;
               if (it_ff == '0) begin
                  state_ff <= S_DIFF;
               end
            end
            S_DIFF: begin
               diff_ff  <= alu_res.sum;
               neg_ff   <= alu_res.negative;
               acc_ff   <= '0;
               it_ff    <= IT_W'(FRAC_BITS);
               state_ff <= alu_res.negative ? S_NEG : S_MUL;
            end
            S_NEG: begin
               diff_ff  <= alu_res.sum;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               acc_ff <= alu_res.sum;
               lam_ff <= lam_ff << 1;
               it_ff  <= it_ff - 1'b1;
               if (it_ff == '0) begin
                  state_ff <= S_RND;
               end
            end
            S_RND: begin
               acc_ff   <= alu_res.sum;
               state_ff <= S_FIN;
            end
            S_FIN: begin
               res_ff   <= col_ok ? alu_res.sum[DATA_W-1:0] : '0;
               state_ff <= S_EMIT;
            end
            S_LD_CLAMP: begin
               res_ff   <= col_ok ? y_rd_data : '0;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (emit_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready                    = (state_ff == S_IDLE);
   assign emit_valid                   = (state_ff == S_EMIT);
   assign emit_data.interpolated_value = res_ff;
   assign emit_data.clamp_status       = status_ff;

endmodule

@@ rtl/tli_checker.sv @@
// tli_checker: port-level assertions for table_linear_interpolator, bound to the top
// depends on tli_pkg
module tli_checker
   import tli_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input req_type          req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsp_type          rsp_data,
   input logic             csr_wr_en,
   input logic [CFG_W-1:0] csr_wr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed or dropped while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.clamp_status == STATUS_INTERIOR
                  || rsp_data.clamp_status == STATUS_FIRST
                  || rsp_data.clamp_status == STATUS_LAST))
      else $error("clamp status code out of range");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result item appeared without an evaluation in progress");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.command == CMD_EVALUATE) |=> !req_ready)
      else $error("ready stayed high after an evaluate item");

   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.command != CMD_EVALUATE) |=> req_ready)
      else $error("ready dropped after a write item");

endmodule

bind table_linear_interpolator tli_checker u_checker (.*);

@@ test/table_linear_interpolator_tb.sv @@
// table_linear_interpolator_tb: self-checking bench for the table interpolator, with a
// directed table, table fills per row count, random traffic and a scoreboard.
// Depends on tli_pkg and table_linear_interpolator.
`timescale 1ns / 1ps

module table_linear_interpolator_tb;
   import tli_pkg::*;

   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
   localparam longint Q_MIN = -(longint'(1) << (DATA_W - 1));
   localparam longint Q_MAX = (longint'(1) << (DATA_W - 1)) - 1;
   localparam int NUM_PHASES    = 11;
   localparam int OPS_PER_PHASE = 35;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 200;

   typedef struct {
      logic [CMD_W-1:0]    cmd;
      int unsigned         row;
      int unsigned         col;
      longint              wval;
      longint              qpt;
      bit                  typed;
      longint              yexp;
      logic [STATUS_W-1:0] sexp;
   } directed_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   // shadow copy of the block's tables and row count
   longint      absc_shadow [TABLE_DEPTH];
   longint      ord_shadow [ORD_DEPTH];
   bit          x_written [TABLE_DEPTH];
   bit          y_written [ORD_DEPTH];
   int unsigned rows_used;

   rsp_type       expected_results [$];
   int            mismatch_count = 0;
   int            idle_cycles = 0;
   bit            send_steady = 0;
   bit            hold_request = 0;
   directed_row_type directed_rows [22];
   logic [CFG_W-1:0] row_settings [NUM_PHASES] = '{11'd0, 11'd7, 11'd3, 11'd20, 11'd1,
      11'd12, 11'd5, 11'd9, 11'd30, 11'd2, 11'd16};

   table_linear_interpolator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned rand_bits(input int unsigned nbits);
      longint unsigned w;
      w = {$urandom, $urandom};
      return (nbits >= 64) ? w : (w & ((64'd1 << nbits) - 1));
   endfunction

   function automatic longint rand_span(input longint lo_v, input longint hi_v);
      longint unsigned span;
      if (hi_v <= lo_v) begin
         return lo_v;
      end
      span = longint'(hi_v - lo_v) + 1;
      return lo_v + longint'(rand_bits(64) % span);
   endfunction

   function automatic longint rand48();
      return rand_span(Q_MIN, Q_MAX);
   endfunction

   function automatic longint clip48(input longint v);
      return (v < Q_MIN) ? Q_MIN : ((v > Q_MAX) ? Q_MAX : v);
   endfunction

   // mostly a small step from the previous ordinate, now and then anywhere
   function automatic longint next_ordinate(input longint prev);
      if ($urandom_range(0, 3) == 0) begin
         return rand48();
      end
      return clip48(prev + rand_span(-(longint'(1) << 24), longint'(1) << 24));
   endfunction

   function automatic req_type make_item(input logic [CMD_W-1:0] cmd, input int unsigned row,
                                         input int unsigned col, input longint wv,
                                         input longint qp);
      req_type it;
      it.command       = cmd;
      it.row_index     = ROW_W'(row);
      it.column_select = COL_W'(col);
      it.write_value   = DATA_W'(wv);
      it.query_point   = DATA_W'(qp);
      return it;
   endfunction

   // a column may be evaluated only once every row it can touch has been written
   function automatic bit col_usable(input int unsigned col);
      for (int unsigned r = 0; r < rows_used; r++) begin
         if (!x_written[r] || !y_written[col * TABLE_DEPTH + r]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic int pick_column();
      int c;
      repeat (8) begin
         c = $urandom_range(0, NUM_COLUMNS - 1);
         if (col_usable(c)) begin
            return c;
         end
      end
      for (c = 0; c < NUM_COLUMNS; c++) begin
         if (col_usable(c)) begin
            return c;
         end
      end
      return -1;
   endfunction

   function automatic longint make_query();
      int unsigned i;
      longint a, b;
      case ($urandom_range(0, 9))
         0: begin
            return rand_span(Q_MIN, absc_shadow[0]);
         end
         1: begin
            return ($urandom_range(0, 1) == 0) ? absc_shadow[0] : absc_shadow[rows_used - 1];
         end
         2: begin
            return rand_span(absc_shadow[rows_used - 1], Q_MAX);
         end
         3: begin
            return absc_shadow[$urandom_range(0, rows_used - 1)];
         end
         4: begin
            return rand48();
         end
         default: begin
            i = $urandom_range(0, rows_used - 2);
            a = absc_shadow[i];
            b = absc_shadow[i + 1];
            return (a < b) ? rand_span(a, b) : rand_span(b, a);
         end
      endcase
   endfunction

   // updates the shadow tables and returns 1 when the item yields a result
   function automatic bit predict_result(input req_type it, output rsp_type res);
      longint q, x0, x1, y0, y1, num, den, diff, val;
      longint unsigned lam, mag;
      logic [127:0] wide;
      int unsigned n, lo, cnt, half, probe, off, row, col;
      bit col_ok;
      row    = it.row_index;
      col    = it.column_select;
      col_ok = col < NUM_COLUMNS;
      res    = '0;
      case (it.command)
         CMD_WRITE_ABSCISSA: begin
            absc_shadow[row] = $signed(it.write_value);
            x_written[row]   = 1'b1;
            return 1'b0;
         end
         CMD_WRITE_ORDINATE: begin
            if (col_ok) begin
               ord_shadow[col * TABLE_DEPTH + row] = $signed(it.write_value);
               y_written[col * TABLE_DEPTH + row]  = 1'b1;
            end
            return 1'b0;
         end
         CMD_EVALUATE: begin
         end
         default: begin
            return 1'b0;
         end
      endcase
      n   = rows_used;
      q   = $signed(it.query_point);
      val = 0;
      if (q <= absc_shadow[0]) begin
         res.clamp_status = STATUS_FIRST;
         if (col_ok) val = ord_shadow[col * TABLE_DEPTH];
      end else if (q >= absc_shadow[n - 1]) begin
         res.clamp_status = STATUS_LAST;
         if (col_ok) val = ord_shadow[col * TABLE_DEPTH + n - 1];
      end else begin
         res.clamp_status = STATUS_INTERIOR;
         lo  = 0;
         cnt = n;
         while (cnt > 0) begin
            half  = cnt / 2;
            probe = lo + half;
            if (absc_shadow[probe] < q) begin
               lo  = probe + 1;
               cnt = cnt - half - 1;
            end else begin
               cnt = half;
            end
         end
         off = (lo == 0) ? 0 : lo - 1;
         if (off > n - 2) off = n - 2;
         x0  = absc_shadow[off];
         x1  = absc_shadow[off + 1];
         num = q - x0;
         den = x1 - x0;
         if (den <= 0 || num <= 0) begin
            lam = 0;
         end else if (num >= den) begin
            lam = 64'd1 << FRAC_BITS;
         end else begin
            wide = (128'(num) << FRAC_BITS) / 128'(den);
            lam  = wide[63:0];
         end
         if (col_ok) begin
            y0   = ord_shadow[col * TABLE_DEPTH + off];
            y1   = ord_shadow[col * TABLE_DEPTH + off + 1];
            diff = y1 - y0;
            // blend on the magnitude so that ties round away from zero
            wide = 128'((diff < 0) ? -diff : diff) * 128'(lam) + (128'(1) << (FRAC_BITS - 1));
            wide = wide >> FRAC_BITS;
            mag  = wide[63:0];
            val  = (diff < 0) ? y0 - longint'(mag) : y0 + longint'(mag);
         end
      end
      res.interpolated_value = val[DATA_W-1:0];
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 100) begin
         $display("[%0t] %s", $time, what);
      end
   endtask

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic push_item(input req_type it, input bit typed, input rsp_type typed_rsp);
      int gap;
      int sel;
      rsp_type predicted;
      sel = $urandom_range(0, 99);
      gap = (send_steady || sel < 55) ? 0 :
            ((sel < 94) ? $urandom_range(1, 3) : $urandom_range(8, 40));
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = it;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_result(it, predicted)) begin
         expected_results.push_back(typed ? typed_rsp : predicted);
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_idle();
      while (expected_results.size() != 0) @(negedge clock);
      // writes give no result, so let the last of them settle
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_row_count(input logic [CFG_W-1:0] setting);
      wait_idle();
      csr_wr_data = setting;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      rows_used = (setting < 2) ? 2 : ((setting > TABLE_DEPTH) ? TABLE_DEPTH : setting);
   endtask

   // ascending abscissae of a random scale, then a few ordinate columns
   task automatic fill_table();
      longint step_len [TABLE_DEPTH];
      longint total, x, y;
      int unsigned r, scale, ncols, col;
      total = 0;
      scale = $urandom_range(0, 46 - $clog2(rows_used));
      for (r = 1; r < rows_used; r++) begin
         step_len[r] = 1 + longint'(rand_bits($urandom_range(0, scale)));
         total += step_len[r];
      end
      x = rand_span(Q_MIN, Q_MAX - total);
      for (r = 0; r < rows_used; r++) begin
         if (r > 0) x += step_len[r];
         push_item(make_item(CMD_WRITE_ABSCISSA, r, $urandom_range(0, 15), x, rand48()),
                   1'b0, '0);
      end
      ncols = (rows_used > 64) ? 1 : $urandom_range(1, 3);
      repeat (ncols) begin
         col = $urandom_range(0, NUM_COLUMNS - 1);
         y   = rand48();
         for (r = 0; r < rows_used; r++) begin
            y = next_ordinate(y);
            push_item(make_item(CMD_WRITE_ORDINATE, r, col, y, rand48()), 1'b0, '0);
         end
      end
   endtask

   // scoreboard
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with no item outstanding: value %h status %0d",
                                      rsp_data.interpolated_value, rsp_data.clamp_status));
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.interpolated_value !== want.interpolated_value) begin
               report_mismatch($sformatf("interpolated_value: got %h, want %h",
                                         rsp_data.interpolated_value,
                                         want.interpolated_value));
            end
            if (rsp_data.clamp_status !== want.clamp_status) begin
               report_mismatch($sformatf("clamp_status: got %0d, want %0d",
                                         rsp_data.clamp_status, want.clamp_status));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("table_linear_interpolator: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stalls, steady stretches and the occasional long hold-off
   initial begin : result_sink
      int stall_left;
      int run_left;
      bit steady;
      rsp_ready  = 1'b0;
      stall_left = 0;
      run_left   = 0;
      steady     = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready    = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (run_left == 0) begin
            steady   = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(100, 300);
         end
         run_left--;
         if (steady) begin
            rsp_ready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready  = 1'b0;
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   initial begin : stimulus
      directed_row_type d;
      rsp_type typed_rsp;
      int phase, done_ops, sel, col;
      int unsigned row;
      longint wv, lo_b, hi_b;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      rows_used   = VALID_ENTRIES_RESET;
      directed_rows = '{
         '{CMD_WRITE_ABSCISSA, 0, 0, Q_MIN, 0, 0, 0, STATUS_INTERIOR},
         '{CMD_WRITE_ABSCISSA, 1, 0, Q_MAX, 0, 0, 0, STATUS_INTERIOR},
         '{CMD_WRITE_ORDINATE, 0, 0, Q_MAX, 0, 0, 0, STATUS_INTERIOR},
         '{CMD_WRITE_ORDINATE, 1, 0, Q_MIN, 0, 0, 0, STATUS_INTERIOR},
         '{CMD_WRITE_ORDINATE, 0, 8, 0, 0, 0, 0, STATUS_INTERIOR},
         '{CMD_WRITE_ORDINATE, 1, 8, 1, 0, 0, 0, STATUS_INTERIOR},
         // column beyond the table: write dropped
         '{CMD_WRITE_ORDINATE, 0, 15, Q_MAX, 0, 0, 0, STATUS_INTERIOR},
         '{CMD_RESERVED, 1023, 15, -1, -1, 0, 0, STATUS_INTERIOR},
         '{CMD_EVALUATE, 0, 0, 0, Q_MIN, 1, Q_MAX, STATUS_FIRST},
         '{CMD_EVALUATE, 1023, 0, -1, Q_MAX, 1, Q_MIN, STATUS_LAST},
         '{CMD_EVALUATE, 0, 0, 0, 0, 0, 0, STATUS_INTERIOR},
         '{CMD_EVALUATE, 0, 8, 0, -1, 0, 0, STATUS_INTERIOR},
         '{CMD_EVALUATE, 0, 15, 0, 0, 1, 0, STATUS_INTERIOR},
         '{CMD_EVALUATE, 0, 9, 0, Q_MIN, 1, 0, STATUS_FIRST},
         '{CMD_WRITE_ABSCISSA, 0, 0, 0, 0, 0, 0, STATUS_INTERIOR},
         '{CMD_WRITE_ABSCISSA, 1, 0, 2, 0, 0, 0, STATUS_INTERIOR},
         // exact half step, rounding away from zero both ways
         '{CMD_EVALUATE, 0, 8, 0, 1, 0, 0, STATUS_INTERIOR},
         '{CMD_WRITE_ORDINATE, 1, 8, -1, 0, 0, 0, STATUS_INTERIOR},
         '{CMD_EVALUATE, 0, 8, 0, 1, 0, 0, STATUS_INTERIOR},
         '{CMD_EVALUATE, 0, 8, 0, 2, 1, -1, STATUS_LAST},
         '{CMD_EVALUATE, 0, 8, 0, 0, 1, 0, STATUS_FIRST},
         '{CMD_EVALUATE, 0, 0, 0, -5, 1, Q_MAX, STATUS_FIRST}
      };
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         d = directed_rows[i];
         typed_rsp.interpolated_value = DATA_W'(d.yexp);
         typed_rsp.clamp_status       = d.sexp;
         push_item(make_item(d.cmd, d.row, d.col, d.wval, d.qpt), d.typed, typed_rsp);
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         set_row_count(row_settings[phase]);
         send_steady = ($urandom_range(0, 3) == 0);
         if (rows_used <= 64 || pick_column() < 0) begin
            fill_table();
         end
         // results back up while items keep coming
         if (phase == 1 || phase == 6) hold_request = 1'b1;
         done_ops = 0;
         while (done_ops < OPS_PER_PHASE) begin
            sel = $urandom_range(0, 99);
            col = pick_column();
            if (sel < 60 && col >= 0) begin
               push_item(make_item(CMD_EVALUATE, $urandom_range(0, 1023), col, rand48(),
                                   make_query()), 1'b0, '0);
               done_ops++;
            end else if (sel < 65 || sel < 60) begin
               push_item(make_item(CMD_EVALUATE, $urandom_range(0, 1023),
                                   $urandom_range(NUM_COLUMNS, 15), rand48(), make_query()),
                         1'b0, '0);
               done_ops++;
            end else if (sel < 77) begin
               row = $urandom_range(0, rows_used - 1);
               col = $urandom_range(0, NUM_COLUMNS - 1);
               wv  = next_ordinate(ord_shadow[col * TABLE_DEPTH + row]);
               push_item(make_item(CMD_WRITE_ORDINATE, row, col, wv, rand48()), 1'b0, '0);
               done_ops++;
            end else if (sel < 87) begin
               row = $urandom_range(0, rows_used - 1);
               if ($urandom_range(0, 3) == 0) begin
                  // may leave the abscissae out of order
                  wv = rand48();
               end else begin
                  lo_b = (row > 0) ? absc_shadow[row - 1] + 1 : Q_MIN;
                  hi_b = (row < rows_used - 1) ? absc_shadow[row + 1] - 1 : Q_MAX;
                  wv   = (lo_b <= hi_b) ? rand_span(lo_b, hi_b) : absc_shadow[row];
               end
               push_item(make_item(CMD_WRITE_ABSCISSA, row, $urandom_range(0, 15), wv,
                                   rand48()), 1'b0, '0);
               done_ops++;
            end else if (sel < 92) begin
               push_item(make_item(CMD_WRITE_ORDINATE, $urandom_range(0, 1023),
                                   $urandom_range(NUM_COLUMNS, 15), rand48(), rand48()),
                         1'b0, '0);
            end else if (sel < 96) begin
               push_item(make_item(CMD_RESERVED, $urandom_range(0, 1023),
                                   $urandom_range(0, 15), rand48(), rand48()), 1'b0, '0);
            end else begin
               push_item(make_item(($urandom_range(0, 1) == 0) ? CMD_WRITE_ABSCISSA
                                                               : CMD_WRITE_ORDINATE,
                                   $urandom_range(0, 1023), $urandom_range(0, NUM_COLUMNS - 1),
                                   rand48(), rand48()), 1'b0, '0);
               done_ops++;
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("table_linear_interpolator: match");
      end else begin
         $display("table_linear_interpolator: mismatch");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/tli_pkg.sv
rtl/tli_ram.sv
rtl/tli_alu.sv
rtl/tli_seq.sv
rtl/table_linear_interpolator.sv
rtl/tli_checker.sv
test/table_linear_interpolator_tb.sv
